// ===== rtl/core/stepper_servo_motion_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Stepper and servo sequencer assertion macros
// Shared assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_SERVO_MOTION_SEQUENCER_TOP_DEFINES_SVH
`define STEPPER_SERVO_MOTION_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SMSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SMSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

// ===== rtl/core/smsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper and servo sequencer package
// Codes, reset values, the half-step table and shared types.
// ----------------------------------------------------------------------------
package smsq_pkg;

  localparam int unsigned POS_W      = 8;
  localparam int unsigned COIL_W     = 4;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // Event kinds carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_SERVO   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWEEP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEPPER = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UPPER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOWER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_INTERVAL = 2'd2;

  localparam logic [POS_W-1:0] SWEEP_UPPER_RST   = 8'd35;
  localparam logic [POS_W-1:0] SWEEP_LOWER_RST   = 8'd8;
  localparam logic [POS_W-1:0] FLIP_INTERVAL_RST = 8'd10;
  localparam logic [POS_W-1:0] POSITION_RST      = 8'd25;
  localparam logic [POS_W-1:0] POSITION_MAX      = 8'd255;

  typedef struct packed {
    logic [POS_W-1:0] sweep_upper;
    logic [POS_W-1:0] sweep_lower;
    logic [POS_W-1:0] flip_interval;
  } cfg_t;

  // Visible part of the sequencer state.
  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              pulse_high;
    logic [POS_W-1:0]  reload_value;
    logic [POS_W-1:0]  position;
    logic              dir_forward;
  } status_t;

  function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pattern;
    case (phase)
      3'd0: pattern = 4'd3;
      3'd1: pattern = 4'd2;
      3'd2: pattern = 4'd6;
      3'd3: pattern = 4'd4;
      3'd4: pattern = 4'd12;
      3'd5: pattern = 4'd8;
      3'd6: pattern = 4'd9;
      default: pattern = 4'd1;
    endcase
    return pattern;
  endfunction

endpackage

// ===== rtl/core/smsq_state.sv =====
// ----------------------------------------------------------------------------
// Sequencer state
// Holds servo, sweep and stepper state and computes the update for one word.
// ----------------------------------------------------------------------------
module smsq_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [smsq_pkg::MODE_W-1:0]   mode,
  input  logic                          enabled,
  input  smsq_pkg::cfg_t                cfg,
  output smsq_pkg::status_t             status,
  output smsq_pkg::status_t             status_next
);

  logic [smsq_pkg::POS_W-1:0]   position, position_next;
  logic                         sweep_down, sweep_down_next;
  logic [smsq_pkg::POS_W-1:0]   flip_count, flip_count_next;
  logic                         dir_forward, dir_forward_next;
  logic [smsq_pkg::PHASE_W-1:0] step_phase, step_phase_next;
  logic [smsq_pkg::COIL_W-1:0]  coils, coils_next;
  logic                         pulse_high, pulse_high_next;
  logic [smsq_pkg::POS_W-1:0]   reload_value, reload_value_next;
  logic [smsq_pkg::POS_W-1:0]   flip_inc;
  logic [smsq_pkg::POS_W-1:0]   pos_moved;

  always_comb begin
    position_next     = position;
    sweep_down_next   = sweep_down;
    flip_count_next   = flip_count;
    dir_forward_next  = dir_forward;
    step_phase_next   = step_phase;
    coils_next        = coils;
    pulse_high_next   = pulse_high;
    reload_value_next = reload_value;
    flip_inc          = flip_count + 8'd1;
    pos_moved         = position;

    if (enabled) begin
      case (mode)
        smsq_pkg::MODE_SERVO: begin
          // A high phase reloads the complement of the position.
          pulse_high_next   = !pulse_high;
          reload_value_next = pulse_high ? position : (smsq_pkg::POSITION_MAX - position);
        end
        smsq_pkg::MODE_SWEEP: begin
          if (flip_inc == cfg.flip_interval) begin
            dir_forward_next = !dir_forward;
            flip_count_next  = '0;
          end else begin
            flip_count_next  = flip_inc;
          end
          // The position saturates at both ends before the bounds are tested.
          if (!sweep_down) begin
            pos_moved = (position == smsq_pkg::POSITION_MAX) ? position : position + 8'd1;
            if (pos_moved >= cfg.sweep_upper) begin
              sweep_down_next = 1'b1;
            end
          end else begin
            pos_moved = (position == '0) ? position : position - 8'd1;
            if (pos_moved <= cfg.sweep_lower) begin
              sweep_down_next = 1'b0;
            end
          end
          position_next = pos_moved;
        end
        smsq_pkg::MODE_STEPPER: begin
          coils_next      = smsq_pkg::half_step(step_phase);
          step_phase_next = dir_forward ? step_phase + 3'd1 : step_phase - 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= smsq_pkg::POSITION_RST;
      sweep_down   <= 1'b0;
      flip_count   <= '0;
      dir_forward  <= 1'b0;
      step_phase   <= '0;
      coils        <= '0;
      pulse_high   <= 1'b0;
      reload_value <= '0;
    end else if (advance) begin
      position     <= position_next;
      sweep_down   <= sweep_down_next;
      flip_count   <= flip_count_next;
      dir_forward  <= dir_forward_next;
      step_phase   <= step_phase_next;
      coils        <= coils_next;
      pulse_high   <= pulse_high_next;
      reload_value <= reload_value_next;
    end
  end

  assign status.coils        = coils;
  assign status.pulse_high   = pulse_high;
  assign status.reload_value = reload_value;
  assign status.position     = position;
  assign status.dir_forward  = dir_forward;

  assign status_next.coils        = coils_next;
  assign status_next.pulse_high   = pulse_high_next;
  assign status_next.reload_value = reload_value_next;
  assign status_next.position     = position_next;
  assign status_next.dir_forward  = dir_forward_next;

endmodule

// ===== rtl/core/stepper_servo_motion_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Stepper and servo motion sequencer
// Tick events drive a servo pulse phase, a triangle sweep and a half-step
// stepper; each event word yields one output word with the new outputs.
// ----------------------------------------------------------------------------
//   Channel  Handshake                 Payload
//   input    in_valid / in_stall       mode, motors_enabled
//   output   out_valid / out_stall     coil_pattern, servo_level, phase_reload,
//                                      servo_position, forward
//   config   cfg_write                 cfg_index, cfg_data
//
// One word per cycle while the output is not stalled. A word is held in the
// input register, then moves on to the output register. Reset is synchronous
// and brings up state, configuration and valid flags at their defaults.
// A stalled output holds its word; the input register still fills behind it.
// ----------------------------------------------------------------------------
`include "stepper_servo_motion_sequencer_top_defines.svh"

module stepper_servo_motion_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smsq_pkg::MODE_W-1:0]       mode,
  input  logic                              motors_enabled,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smsq_pkg::COIL_W-1:0]       coil_pattern,
  output logic                              servo_level,
  output logic [smsq_pkg::POS_W-1:0]        phase_reload,
  output logic [smsq_pkg::POS_W-1:0]        servo_position,
  output logic                              forward,
  input  logic                              cfg_write,
  input  logic [smsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                        a_valid;
  logic [smsq_pkg::MODE_W-1:0] a_mode;
  logic                        a_enabled;
  logic                        advance;
  logic                        accept_in;
  smsq_pkg::cfg_t              cfg;
  smsq_pkg::status_t           status;
  smsq_pkg::status_t           status_next;

  // The held word moves on when the output register is empty or draining.
  assign advance   = a_valid && (!out_valid || !out_stall);
  assign in_stall  = a_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_upper   <= smsq_pkg::SWEEP_UPPER_RST;
      cfg.sweep_lower   <= smsq_pkg::SWEEP_LOWER_RST;
      cfg.flip_interval <= smsq_pkg::FLIP_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        smsq_pkg::REG_SWEEP_UPPER:   cfg.sweep_upper   <= cfg_data;
        smsq_pkg::REG_SWEEP_LOWER:   cfg.sweep_lower   <= cfg_data;
        smsq_pkg::REG_FLIP_INTERVAL: cfg.flip_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept_in) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      a_mode    <= mode;
      a_enabled <= motors_enabled;
    end
    if (advance) begin
      coil_pattern   <= status_next.coils;
      servo_level    <= a_enabled && status_next.pulse_high;
      phase_reload   <= status_next.reload_value;
      servo_position <= status_next.position;
      forward        <= status_next.dir_forward;
    end
  end

  smsq_state u_state (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .mode        (a_mode),
    .enabled     (a_enabled),
    .cfg         (cfg),
    .status      (status),
    .status_next (status_next)
  );

  `SMSQ_ASSERT_IMP(a_disabled_holds, clk, rst, advance && !a_enabled, status_next == status)
  `SMSQ_ASSERT_IMP(a_pos_only_on_sweep, clk, rst,
    advance && a_mode != smsq_pkg::MODE_SWEEP, status_next.position == status.position)
  `SMSQ_ASSERT_IMP(a_coil_half_step, clk, rst, out_valid && coil_pattern != '0,
    $countones(coil_pattern) == 1 || $countones(coil_pattern) == 2)
  `SMSQ_ASSERT_NEXT(a_advance_fills_out, clk, rst, advance, out_valid)

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Motion sequencer testbench
// Feeds tick words through the sequencer with random gaps and output stalls.
// A predictor of the servo phase, the sweep and the stepper works out each
// expected output word. Each word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // Half-step coil patterns, phase 0 in the low nibble.
  localparam logic [31:0] HALF_STEP_SEQ =
    {4'd1, 4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3};
  // The fourth mode value has no effect on the sequencer.
  localparam logic [smsq_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [smsq_pkg::MODE_W-1:0] kind;
    logic                        enabled;
  } tick_t;

  typedef struct packed {
    logic [smsq_pkg::COIL_W-1:0] coils;
    logic                        level;
    logic [smsq_pkg::POS_W-1:0]  reload;
    logic [smsq_pkg::POS_W-1:0]  pos;
    logic                        fwd;
  } motion_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [smsq_pkg::MODE_W-1:0] mode = '0;
  logic motors_enabled = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [smsq_pkg::COIL_W-1:0] coil_pattern;
  logic servo_level;
  logic [smsq_pkg::POS_W-1:0] phase_reload;
  logic [smsq_pkg::POS_W-1:0] servo_position;
  logic forward;
  logic cfg_write = 1'b0;
  logic [smsq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [smsq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor configuration and state.
  logic [smsq_pkg::POS_W-1:0] upper_bound = smsq_pkg::SWEEP_UPPER_RST;
  logic [smsq_pkg::POS_W-1:0] lower_bound = smsq_pkg::SWEEP_LOWER_RST;
  logic [smsq_pkg::POS_W-1:0] flip_every = smsq_pkg::FLIP_INTERVAL_RST;
  logic [smsq_pkg::POS_W-1:0] sweep_pos = smsq_pkg::POSITION_RST;
  logic sweep_falling = 1'b0;
  logic [7:0] flip_cnt = '0;
  logic dir_fwd = 1'b0;
  logic [smsq_pkg::PHASE_W-1:0] step_ph = '0;
  logic [smsq_pkg::COIL_W-1:0] coil_now = '0;
  logic pulse_on = 1'b0;
  logic [smsq_pkg::POS_W-1:0] reload_now = '0;

  tick_t tick_queue[$];
  motion_word_t due_words[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit word_taken = 1'b0;
  bit quiet = 1'b0;

  stepper_servo_motion_sequencer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .motors_enabled(motors_enabled),
    .out_valid(out_valid), .out_stall(out_stall),
    .coil_pattern(coil_pattern), .servo_level(servo_level),
    .phase_reload(phase_reload), .servo_position(servo_position),
    .forward(forward),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic motion_word_t apply_tick(input logic [smsq_pkg::MODE_W-1:0] kind,
                                              input logic enabled);
    motion_word_t w;
    if (enabled) begin
      case (kind)
        smsq_pkg::MODE_SERVO: begin
          pulse_on = !pulse_on;
          reload_now = pulse_on ? smsq_pkg::POSITION_MAX - sweep_pos : sweep_pos;
        end
        smsq_pkg::MODE_SWEEP: begin
          flip_cnt = flip_cnt + 8'd1;
          if (flip_cnt == flip_every) begin
            dir_fwd = !dir_fwd;
            flip_cnt = '0;
          end
          if (!sweep_falling) begin
            if (sweep_pos != smsq_pkg::POSITION_MAX) sweep_pos = sweep_pos + 8'd1;
            if (sweep_pos >= upper_bound) sweep_falling = 1'b1;
          end else begin
            if (sweep_pos != '0) sweep_pos = sweep_pos - 8'd1;
            if (sweep_pos <= lower_bound) sweep_falling = 1'b0;
          end
        end
        smsq_pkg::MODE_STEPPER: begin
          coil_now = HALF_STEP_SEQ[step_ph*smsq_pkg::COIL_W +: smsq_pkg::COIL_W];
          step_ph = dir_fwd ? step_ph + 3'd1 : step_ph - 3'd1;
        end
        default: begin
        end
      endcase
    end
    w.coils = coil_now;
    w.level = enabled && pulse_on;
    w.reload = reload_now;
    w.pos = sweep_pos;
    w.fwd = dir_fwd;
    return w;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Monitor: outputs are checked before the input side is sampled, since a
  // word taken at this edge cannot leave before the next one.
  always @(posedge clk) begin
    motion_word_t want;
    word_taken = 1'b0;
    cycle_count++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          fail_count++;
          $display("%0t: output word with none expected, expected none actual pos %0d",
                   $time, servo_position);
        end else begin
          want = due_words.pop_front();
          compare_field("coil_pattern", {4'd0, want.coils}, {4'd0, coil_pattern});
          compare_field("servo_level", {7'd0, want.level}, {7'd0, servo_level});
          compare_field("phase_reload", want.reload, phase_reload);
          compare_field("servo_position", want.pos, servo_position);
          compare_field("forward", {7'd0, want.fwd}, {7'd0, forward});
        end
      end
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        due_words.push_back(apply_tick(mode, motors_enabled));
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Driver: a word stays on the port until it is taken.
  always @(negedge clk) begin
    tick_t next_tick;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || word_taken) begin
        if (tick_queue.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          mode <= next_tick.kind;
          motors_enabled <= next_tick.enabled;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  task automatic queue_tick(input logic [smsq_pkg::MODE_W-1:0] kind, input logic enabled);
    tick_t t;
    t.kind = kind;
    t.enabled = enabled;
    tick_queue.push_back(t);
  endtask

  task automatic write_reg(input logic [smsq_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      smsq_pkg::REG_SWEEP_UPPER:   upper_bound = val;
      smsq_pkg::REG_SWEEP_LOWER:   lower_bound = val;
      smsq_pkg::REG_FLIP_INTERVAL: flip_every = val;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // The check waits past the driver's updates at the falling edge, so a word
  // that was just popped is seen as in flight.
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (tick_queue.size() != 0 || in_valid || due_words.size() != 0);
  endtask

  // Random ticks with the sweep share given in percent; a few are disabled
  // and a few carry the unused mode.
  task automatic run_phase(input logic [7:0] upper, input logic [7:0] lower,
                           input logic [7:0] flip, input int unsigned count,
                           input int unsigned sweep_pct);
    int unsigned r;
    logic [smsq_pkg::MODE_W-1:0] kind;
    write_reg(smsq_pkg::REG_SWEEP_UPPER, upper);
    write_reg(smsq_pkg::REG_SWEEP_LOWER, lower);
    write_reg(smsq_pkg::REG_FLIP_INTERVAL, flip);
    repeat (count) begin
      r = $urandom_range(99);
      if (r < sweep_pct) kind = smsq_pkg::MODE_SWEEP;
      else if (r < sweep_pct + (100 - sweep_pct) * 9 / 20) kind = smsq_pkg::MODE_SERVO;
      else if (r < 95) kind = smsq_pkg::MODE_STEPPER;
      else kind = MODE_NONE;
      queue_tick(kind, $urandom_range(99) >= 15);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset configuration.
    queue_tick(smsq_pkg::MODE_SERVO, 1'b1);
    queue_tick(smsq_pkg::MODE_SERVO, 1'b1);
    queue_tick(smsq_pkg::MODE_SERVO, 1'b1);
    queue_tick(smsq_pkg::MODE_SERVO, 1'b0);
    queue_tick(MODE_NONE, 1'b1);
    queue_tick(MODE_NONE, 1'b0);
    repeat (3) queue_tick(smsq_pkg::MODE_STEPPER, 1'b1);
    queue_tick(smsq_pkg::MODE_STEPPER, 1'b0);
    queue_tick(smsq_pkg::MODE_SWEEP, 1'b0);
    // Enough sweep ticks to reach the upper bound and flip the direction.
    repeat (11) queue_tick(smsq_pkg::MODE_SWEEP, 1'b1);
    repeat (2) queue_tick(smsq_pkg::MODE_STEPPER, 1'b1);
    queue_tick(smsq_pkg::MODE_SERVO, 1'b1);
    drain();

    // Full-range sweep down to zero and up to the top.
    run_phase(8'd255, 8'd0, 8'd1, 650, 85);
    // Crossed bounds and a wrapping flip counter.
    run_phase(8'd0, 8'd255, 8'd0, 350, 75);
    quiet = 1'b1;
    run_phase(8'd40, 8'd200, 8'd255, 150, 50);
    quiet = 1'b0;
    repeat (3) begin
      run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)), 100, 50);
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
